// ===== hdl/palist_pkg.sv =====
// Shared types, constants and codes for the positional array list engine.
`timescale 1ns / 1ps

package palist_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = 7;
  localparam int IDX_W = 6;
  localparam int DATA_W = 32;
  localparam int CMD_W = 3;
  localparam int STAT_W = 3;
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 48;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CMP_W-1:0] cmp_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IN_TDATA_W-1:0] in_tdata_t;
  typedef logic [OUT_TDATA_W-1:0] out_tdata_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_DISPLAY = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_SEARCH  = 3'd3,
    CMD_UPDATE  = 3'd4
  } cmd_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BAD_CMD   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP,
    S_DOWN,
    S_WRITE,
    S_SEARCH,
    S_FOUND,
    S_DISP_RD,
    S_DISP_OUT,
    S_REPLY
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS1,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic {
    RD_PTR,
    RD_PTR_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_VAL
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    OUT_PLAIN,
    OUT_FOUND,
    OUT_DISP
  } out_sel_t;

  typedef struct packed {
    logic     latch;
    ptr_op_t  ptr_op;
    logic     rd_en;
    rd_sel_t  rd_sel;
    wr_op_t   wr_op;
    cnt_op_t  cnt_op;
    logic     set_status;
    status_t  status;
    logic     load_out;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             full;
    logic             empty;
    logic             ptr_gt_pos;
    logic             ptr_lt_cnt;
    logic             rd_vld;
    logic             match;
    logic             rd_last;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== hdl/palist_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module palist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/palist_ctrl.sv =====
// Command sequencer of the array list engine.
`timescale 1ns / 1ps

module palist_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  palist_pkg::dp_stat_t st,
  output palist_pkg::dp_cmd_t  cmd
);

  palist_pkg::state_t state_r;
  palist_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= palist_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      palist_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = palist_pkg::S_DECIDE;
        end
      end
      palist_pkg::S_DECIDE: begin
        case (st.cmd)
          palist_pkg::CMD_DISPLAY: begin
            state_nxt = st.empty ? palist_pkg::S_REPLY : palist_pkg::S_DISP_RD;
          end
          palist_pkg::CMD_INSERT: begin
            state_nxt = (st.pos_gt_cnt || st.full) ? palist_pkg::S_REPLY : palist_pkg::S_UP;
          end
          palist_pkg::CMD_DELETE: begin
            state_nxt = st.pos_ge_cnt ? palist_pkg::S_REPLY : palist_pkg::S_DOWN;
          end
          palist_pkg::CMD_SEARCH: begin
            state_nxt = palist_pkg::S_SEARCH;
          end
          palist_pkg::CMD_UPDATE: begin
            state_nxt = st.pos_ge_cnt ? palist_pkg::S_REPLY : palist_pkg::S_WRITE;
          end
          default: begin
            state_nxt = palist_pkg::S_REPLY;
          end
        endcase
      end
      palist_pkg::S_UP: begin
        if (!st.ptr_gt_pos && !st.rd_vld) begin
          state_nxt = palist_pkg::S_WRITE;
        end
      end
      palist_pkg::S_WRITE: begin
        state_nxt = palist_pkg::S_REPLY;
      end
      palist_pkg::S_DOWN: begin
        if (!st.ptr_lt_cnt && !st.rd_vld) begin
          state_nxt = palist_pkg::S_REPLY;
        end
      end
      palist_pkg::S_SEARCH: begin
        if (st.match) begin
          state_nxt = palist_pkg::S_FOUND;
        end else if (!st.ptr_lt_cnt && !st.rd_vld) begin
          state_nxt = palist_pkg::S_REPLY;
        end
      end
      palist_pkg::S_FOUND: begin
        if (st.out_free) begin
          state_nxt = palist_pkg::S_IDLE;
        end
      end
      palist_pkg::S_DISP_RD: begin
        state_nxt = palist_pkg::S_DISP_OUT;
      end
      palist_pkg::S_DISP_OUT: begin
        if (st.out_free && st.rd_last) begin
          state_nxt = palist_pkg::S_IDLE;
        end
      end
      palist_pkg::S_REPLY: begin
        if (st.out_free) begin
          state_nxt = palist_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = palist_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = (state_r == palist_pkg::S_IDLE);
    cmd.latch = 1'b0;
    cmd.ptr_op = palist_pkg::PTR_HOLD;
    cmd.rd_en = 1'b0;
    cmd.rd_sel = palist_pkg::RD_PTR;
    cmd.wr_op = palist_pkg::WR_NONE;
    cmd.cnt_op = palist_pkg::CNT_HOLD;
    cmd.set_status = 1'b0;
    cmd.status = palist_pkg::ST_OK;
    cmd.load_out = 1'b0;
    cmd.out_sel = palist_pkg::OUT_PLAIN;
    case (state_r)
      palist_pkg::S_IDLE: begin
        cmd.latch = in_tvalid;
      end
      palist_pkg::S_DECIDE: begin
        case (st.cmd)
          palist_pkg::CMD_DISPLAY: begin
            if (st.empty) begin
              cmd.set_status = 1'b1;
              cmd.status = palist_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_op = palist_pkg::PTR_ZERO;
            end
          end
          palist_pkg::CMD_INSERT: begin
            if (st.pos_gt_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status = palist_pkg::ST_BAD_POS;
            end else if (st.full) begin
              cmd.set_status = 1'b1;
              cmd.status = palist_pkg::ST_FULL;
            end else begin
              cmd.ptr_op = palist_pkg::PTR_COUNT;
            end
          end
          palist_pkg::CMD_DELETE: begin
            if (st.pos_ge_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status = palist_pkg::ST_BAD_POS;
            end else begin
              cmd.ptr_op = palist_pkg::PTR_POS1;
            end
          end
          palist_pkg::CMD_SEARCH: begin
            cmd.ptr_op = palist_pkg::PTR_ZERO;
          end
          palist_pkg::CMD_UPDATE: begin
            if (st.pos_ge_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status = palist_pkg::ST_BAD_POS;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status = palist_pkg::ST_BAD_CMD;
          end
        endcase
      end
      palist_pkg::S_UP: begin
        cmd.rd_sel = palist_pkg::RD_PTR_M1;
        if (st.ptr_gt_pos) begin
          cmd.rd_en = 1'b1;
          cmd.ptr_op = palist_pkg::PTR_DEC;
        end
        if (st.rd_vld) begin
          cmd.wr_op = palist_pkg::WR_UP;
        end
      end
      palist_pkg::S_WRITE: begin
        cmd.wr_op = palist_pkg::WR_VAL;
        cmd.set_status = 1'b1;
        if (st.cmd == palist_pkg::CMD_INSERT) begin
          cmd.cnt_op = palist_pkg::CNT_INC;
        end
      end
      palist_pkg::S_DOWN: begin
        if (st.ptr_lt_cnt) begin
          cmd.rd_en = 1'b1;
          cmd.ptr_op = palist_pkg::PTR_INC;
        end
        if (st.rd_vld) begin
          cmd.wr_op = palist_pkg::WR_DOWN;
        end
        if (!st.ptr_lt_cnt && !st.rd_vld) begin
          cmd.cnt_op = palist_pkg::CNT_DEC;
          cmd.set_status = 1'b1;
        end
      end
      palist_pkg::S_SEARCH: begin
        if (!st.match) begin
          if (st.ptr_lt_cnt) begin
            cmd.rd_en = 1'b1;
            cmd.ptr_op = palist_pkg::PTR_INC;
          end else if (!st.rd_vld) begin
            cmd.set_status = 1'b1;
            cmd.status = palist_pkg::ST_NOT_FOUND;
          end
        end
      end
      palist_pkg::S_FOUND: begin
        cmd.out_sel = palist_pkg::OUT_FOUND;
        cmd.load_out = st.out_free;
      end
      palist_pkg::S_DISP_RD: begin
        cmd.rd_en = 1'b1;
        cmd.ptr_op = palist_pkg::PTR_INC;
      end
      palist_pkg::S_DISP_OUT: begin
        cmd.out_sel = palist_pkg::OUT_DISP;
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          if (!st.rd_last) begin
            cmd.rd_en = 1'b1;
            cmd.ptr_op = palist_pkg::PTR_INC;
          end
        end
      end
      palist_pkg::S_REPLY: begin
        cmd.load_out = st.out_free;
      end
      default: begin
        cmd.latch = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/palist_dp.sv =====
// Datapath of the array list engine: element store, count, pointer and result register.
`timescale 1ns / 1ps

module palist_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  palist_pkg::in_tdata_t         in_tdata,
  input  logic [palist_pkg::CMD_W-1:0]  in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output palist_pkg::out_tdata_t        out_tdata,
  output logic [palist_pkg::STAT_W-1:0] out_tuser,
  output logic                          out_tlast,
  input  palist_pkg::dp_cmd_t           cmd,
  output palist_pkg::dp_stat_t          st
);

  logic [palist_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  palist_pkg::pos_t    pos_r, pos_nxt;
  palist_pkg::data_t   val_r, val_nxt;
  palist_pkg::cnt_t    count_r, count_nxt;
  palist_pkg::cnt_t    ptr_r, ptr_nxt;
  palist_pkg::status_t status_r, status_nxt;
  palist_pkg::addr_t   rd_addr_r, rd_addr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  palist_pkg::status_t out_status_r, out_status_nxt;
  palist_pkg::idx_t    out_idx_r, out_idx_nxt;
  palist_pkg::data_t   out_elem_r, out_elem_nxt;
  palist_pkg::cnt_t    out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  palist_pkg::addr_t   rd_addr;
  palist_pkg::addr_t   wr_addr;
  palist_pkg::data_t   wr_data;
  logic                wr_en;
  logic [palist_pkg::DATA_W-1:0] rd_data;
  logic                rd_last;

  palist_ram #(
    .WIDTH(palist_pkg::DATA_W),
    .DEPTH(palist_pkg::CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    if (cmd.rd_sel == palist_pkg::RD_PTR_M1) begin
      rd_addr = palist_pkg::addr_t'(ptr_r - palist_pkg::cnt_t'(1));
    end else begin
      rd_addr = palist_pkg::addr_t'(ptr_r);
    end
    wr_en = (cmd.wr_op != palist_pkg::WR_NONE);
    case (cmd.wr_op)
      palist_pkg::WR_UP: begin
        wr_addr = rd_addr_r + palist_pkg::addr_t'(1);
        wr_data = rd_data;
      end
      palist_pkg::WR_DOWN: begin
        wr_addr = rd_addr_r - palist_pkg::addr_t'(1);
        wr_data = rd_data;
      end
      palist_pkg::WR_VAL: begin
        wr_addr = palist_pkg::addr_t'(pos_r);
        wr_data = val_r;
      end
      default: begin
        wr_addr = rd_addr_r;
        wr_data = rd_data;
      end
    endcase
  end

  assign rd_last = ((palist_pkg::cnt_t'(rd_addr_r) + palist_pkg::cnt_t'(1)) == count_r);

  always_comb begin
    st.cmd = cmd_r;
    st.pos_gt_cnt = (palist_pkg::cmp_t'(pos_r) > palist_pkg::cmp_t'(count_r));
    st.pos_ge_cnt = (palist_pkg::cmp_t'(pos_r) >= palist_pkg::cmp_t'(count_r));
    st.full = (count_r == palist_pkg::cnt_t'(palist_pkg::CAPACITY));
    st.empty = (count_r == '0);
    st.ptr_gt_pos = (palist_pkg::cmp_t'(ptr_r) > palist_pkg::cmp_t'(pos_r));
    st.ptr_lt_cnt = (ptr_r < count_r);
    st.rd_vld = rd_vld_r;
    st.match = rd_vld_r && (rd_data == val_r);
    st.rd_last = rd_last;
    st.out_free = !out_tvalid_r || out_tready;
  end

  always_comb begin
    cmd_nxt = cmd_r;
    pos_nxt = pos_r;
    val_nxt = val_r;
    if (cmd.latch) begin
      cmd_nxt = in_tuser;
      pos_nxt = in_tdata[palist_pkg::POS_W-1:0];
      val_nxt = in_tdata[palist_pkg::POS_W +: palist_pkg::DATA_W];
    end

    case (cmd.ptr_op)
      palist_pkg::PTR_ZERO:  ptr_nxt = '0;
      palist_pkg::PTR_COUNT: ptr_nxt = count_r;
      palist_pkg::PTR_POS1:  ptr_nxt = palist_pkg::cnt_t'(pos_r) + palist_pkg::cnt_t'(1);
      palist_pkg::PTR_INC:   ptr_nxt = ptr_r + palist_pkg::cnt_t'(1);
      palist_pkg::PTR_DEC:   ptr_nxt = ptr_r - palist_pkg::cnt_t'(1);
      default:               ptr_nxt = ptr_r;
    endcase

    case (cmd.cnt_op)
      palist_pkg::CNT_INC: count_nxt = count_r + palist_pkg::cnt_t'(1);
      palist_pkg::CNT_DEC: count_nxt = count_r - palist_pkg::cnt_t'(1);
      default:             count_nxt = count_r;
    endcase

    status_nxt = cmd.set_status ? cmd.status : status_r;
    rd_vld_nxt = cmd.rd_en;
    rd_addr_nxt = cmd.rd_en ? rd_addr : rd_addr_r;

    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_idx_nxt = out_idx_r;
    out_elem_nxt = out_elem_r;
    out_count_nxt = out_count_r;
    out_last_nxt = out_last_r;
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
      out_count_nxt = count_r;
      case (cmd.out_sel)
        palist_pkg::OUT_FOUND: begin
          out_status_nxt = palist_pkg::ST_OK;
          out_idx_nxt = palist_pkg::idx_t'(rd_addr_r);
          out_elem_nxt = '0;
          out_last_nxt = 1'b1;
        end
        palist_pkg::OUT_DISP: begin
          out_status_nxt = palist_pkg::ST_OK;
          out_idx_nxt = palist_pkg::idx_t'(rd_addr_r);
          out_elem_nxt = rd_data;
          out_last_nxt = rd_last;
        end
        default: begin
          out_status_nxt = status_r;
          out_idx_nxt = '0;
          out_elem_nxt = '0;
          out_last_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_vld_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    ptr_r <= ptr_nxt;
    status_r <= status_nxt;
    rd_addr_r <= rd_addr_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r <= out_idx_nxt;
    out_elem_r <= out_elem_nxt;
    out_count_r <= out_count_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser = out_status_r;
  assign out_tlast = out_last_r;
  assign out_tdata = palist_pkg::out_tdata_t'({out_count_r, out_elem_r, out_idx_r});

endmodule

// ===== hdl/positional_array_list_engine_core.sv =====
// Top level of the positional array list engine.
//
//   Channel  Direction  Handshake          Payload
//   in_      sink       tvalid / tready    tuser command, tdata position and data_value
//   out_     source     tvalid / tready    tuser status, tdata index, element, count; tlast
//
// Insert shifts the elements from position upward, delete shifts those after position down,
// and search reads from index 0 until a hit or the end of the list; update and rejected
// commands walk no elements. Each walk reads the element RAM one element per cycle
// through its single read port. Display gives one beat per cycle while out_ is not stalled.
// Reset empties the list at once; the element RAM holds no reset value.
// A stalled result beat holds the sequencer; the next command can be taken in the cycle after
// the final beat of the current one has been loaded.
`timescale 1ns / 1ps

module positional_array_list_engine_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [6:0] position, [38:7] data_value, [39] zero
  input  palist_pkg::in_tdata_t         in_tdata,
  // [2:0] command
  input  logic [palist_pkg::CMD_W-1:0]  in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [5:0] index, [37:6] element, [44:38] count, [47:45] zero
  output palist_pkg::out_tdata_t        out_tdata,
  // [2:0] status
  output logic [palist_pkg::STAT_W-1:0] out_tuser,
  output logic                          out_tlast
);

  palist_pkg::dp_cmd_t  dp_cmd;
  palist_pkg::dp_stat_t dp_stat;

  palist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .st       (dp_stat),
    .cmd      (dp_cmd)
  );

  palist_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cmd       (dp_cmd),
    .st        (dp_stat)
  );

endmodule

// ===== hdl/palist_chk.sv =====
// Port-level checker for the positional array list engine, bound to the top level.
`timescale 1ns / 1ps

module palist_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input palist_pkg::in_tdata_t         in_tdata,
  input logic [palist_pkg::CMD_W-1:0]  in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input palist_pkg::out_tdata_t        out_tdata,
  input logic [palist_pkg::STAT_W-1:0] out_tuser,
  input logic                          out_tlast
);

  // A stalled result beat stays valid.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // The reported count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[44:38] <= palist_pkg::CAPACITY)
    else $error("count above capacity");

  // Any non-ok status ends its command and carries no element.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != palist_pkg::ST_OK |-> out_tlast && out_tdata[37:6] == '0)
    else $error("error beat not final or carries an element");

  // No command is taken while a display run is still in progress.
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("command accepted in the middle of a display run");

endmodule

bind positional_array_list_engine_core palist_chk u_palist_chk (.*);
